@@ rtl/core/vector3_geometry_unit_core_assert.svh @@
// Assertion helpers for the vector3 geometry unit. They expect clk and rst_n in scope.
`ifndef VECTOR3_GEOMETRY_UNIT_CORE_ASSERT_SVH
`define VECTOR3_GEOMETRY_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define VGU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vgu assertion failed");

// next-cycle implication
`define VGU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vgu assertion failed");

`endif

@@ rtl/core/vgu_pkg.sv @@
package vgu_pkg;

  localparam int COMP_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * COMP_W;
  localparam int CRS_W     = PROD_W + 1;
  localparam int DOT_W     = PROD_W + 2;
  localparam int SQ_W      = PROD_W - 1;
  localparam int SUM_W     = PROD_W;
  localparam int REM_W     = SUM_W + 1;
  localparam int QUO_W     = 2 * FRAC_BITS + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int LEN_STEPS = SUM_W / 2;
  localparam int NRM_XW    = QUO_W + 1;
  localparam int NRM_STEPS = (QUO_W + 1) / 2;
  localparam int NRM_W     = NRM_STEPS;
  localparam int TAIL_STAGES = DIV_STEPS + NRM_STEPS;
  localparam int NUM_MUL   = 6;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam comp_t COMP_MAX = comp_t'({1'b0, {(COMP_W-1){1'b1}}});
  localparam comp_t COMP_MIN = comp_t'({1'b1, {(COMP_W-1){1'b0}}});

  typedef enum logic [2:0] {
    MODE_DOT   = 3'd0,
    MODE_CROSS = 3'd1,
    MODE_LEN   = 3'd2,
    MODE_NORM  = 3'd3,
    MODE_PERP  = 3'd4,
    MODE_PTEST = 3'd5
  } mode_t;

  typedef struct packed {
    comp_t v;
    logic  ov;
  } sat_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] q;
  } div_t;

  typedef struct packed {
    logic [SUM_W-1:0] x;
    logic [SUM_W-1:0] res;
  } lsq_t;

  typedef struct packed {
    logic [NRM_XW-1:0] x;
    logic [NRM_XW-1:0] res;
  } nsq_t;

  // one transaction as it moves down the iterative tail
  typedef struct packed {
    mode_t            mode;
    logic [2:0]       neg;
    logic [SUM_W-1:0] s;
    comp_t [2:0]      r;
    comp_t            sc;
    logic             flag;
    logic             ov;
    div_t [2:0]       dv;
    lsq_t             len;
    nsq_t [2:0]       nrm;
  } tail_t;

  // floor shift by FRAC_BITS, then clamp to the component range
  function automatic sat_t sat_shift(logic signed [DOT_W-1:0] v);
    logic signed [DOT_W-1:0] sh;
    sat_t o;
    sh = v >>> FRAC_BITS;
    if ((&sh[DOT_W-1:COMP_W-1]) || !(|sh[DOT_W-1:COMP_W-1])) begin
      o.v  = sh[COMP_W-1:0];
      o.ov = 1'b0;
    end else begin
      o.v  = sh[DOT_W-1] ? COMP_MIN : COMP_MAX;
      o.ov = 1'b1;
    end
    return o;
  endfunction

  // one restoring divide step
  function automatic div_t div_step(div_t a, logic [SUM_W-1:0] s, logic shift);
    logic [REM_W-1:0] r;
    logic [QUO_W-1:0] q;
    div_t o;
    r = shift ? {a.rem[REM_W-2:0], 1'b0} : a.rem;
    q = shift ? {a.q[QUO_W-2:0], 1'b0} : a.q;
    if (r >= {1'b0, s}) begin
      r    = r - {1'b0, s};
      q[0] = 1'b1;
    end
    o.rem = r;
    o.q   = q;
    return o;
  endfunction

  // one digit of the bitwise integer square root
  function automatic lsq_t lsq_step(lsq_t a, logic [SUM_W-1:0] bv);
    logic [SUM_W-1:0] trial;
    lsq_t o;
    trial = a.res + bv;
    if (a.x >= trial) begin
      o.x   = a.x - trial;
      o.res = (a.res >> 1) + bv;
    end else begin
      o.x   = a.x;
      o.res = a.res >> 1;
    end
    return o;
  endfunction

  function automatic nsq_t nsq_step(nsq_t a, logic [NRM_XW-1:0] bv);
    logic [NRM_XW-1:0] trial;
    nsq_t o;
    trial = a.res + bv;
    if (a.x >= trial) begin
      o.x   = a.x - trial;
      o.res = (a.res >> 1) + bv;
    end else begin
      o.x   = a.x;
      o.res = a.res >> 1;
    end
    return o;
  endfunction

endpackage

@@ rtl/core/vgu_front.sv @@
// Multiply, sum and dot/cross finish: three register stages.
module vgu_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [2:0]            mode,
  input  logic signed [31:0]    a_x,
  input  logic signed [31:0]    a_y,
  input  logic signed [31:0]    a_z,
  input  logic signed [31:0]    b_x,
  input  logic signed [31:0]    b_y,
  input  logic signed [31:0]    b_z,
  output logic                  out_vld,
  output vgu_pkg::tail_t        out_dat
);

  vgu_pkg::comp_t oa [vgu_pkg::NUM_MUL];
  vgu_pkg::comp_t ob [vgu_pkg::NUM_MUL];
  vgu_pkg::prod_t prd_nxt [vgu_pkg::NUM_MUL];
  logic [2:0]     neg_nxt;

  logic           vld_a_r;
  vgu_pkg::mode_t mode_a_r;
  logic [2:0]     neg_a_r;
  vgu_pkg::prod_t prd_a_r [vgu_pkg::NUM_MUL];

  logic                                 vld_b_r;
  vgu_pkg::mode_t                       mode_b_r;
  logic [2:0]                           neg_b_r;
  logic signed [vgu_pkg::DOT_W-1:0]     dot_b_r, dot_nxt;
  logic signed [vgu_pkg::CRS_W-1:0]     crs_b_r [3];
  logic signed [vgu_pkg::CRS_W-1:0]     crs_nxt [3];
  logic [vgu_pkg::SUM_W-1:0]            s_b_r, s_nxt;
  logic [vgu_pkg::SQ_W-1:0]             sq_b_r [3];

  logic           vld_c_r;
  vgu_pkg::tail_t dat_c_r, dat_c_nxt;

  // stage A: operand select and six multipliers
  always_comb begin
    for (int k = 0; k < vgu_pkg::NUM_MUL; k++) begin
      oa[k] = '0;
      ob[k] = '0;
    end
    neg_nxt = '0;
    unique case (vgu_pkg::mode_t'(mode))
      vgu_pkg::MODE_DOT, vgu_pkg::MODE_PTEST: begin
        oa[0] = a_x; ob[0] = b_x;
        oa[1] = a_y; ob[1] = b_y;
        oa[2] = a_z; ob[2] = b_z;
      end
      vgu_pkg::MODE_CROSS: begin
        oa[0] = a_y; ob[0] = b_z;
        oa[1] = a_z; ob[1] = b_y;
        oa[2] = a_z; ob[2] = b_x;
        oa[3] = a_x; ob[3] = b_z;
        oa[4] = a_x; ob[4] = b_y;
        oa[5] = a_y; ob[5] = b_x;
      end
      vgu_pkg::MODE_LEN, vgu_pkg::MODE_NORM: begin
        oa[0] = a_x; ob[0] = a_x;
        oa[1] = a_y; ob[1] = a_y;
        oa[2] = a_z; ob[2] = a_z;
        neg_nxt = {a_z[31], a_y[31], a_x[31]};
      end
      vgu_pkg::MODE_PERP: begin
        // rotated vector is (-a_y, a_x, a_z)
        oa[0] = a_y; ob[0] = a_y;
        oa[1] = a_x; ob[1] = a_x;
        oa[2] = a_z; ob[2] = a_z;
        neg_nxt = {a_z[31], a_x[31], (!a_y[31] && (a_y != '0))};
      end
      default: begin
      end
    endcase
    for (int k = 0; k < vgu_pkg::NUM_MUL; k++) begin
      prd_nxt[k] = oa[k] * ob[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_a_r <= vgu_pkg::mode_t'(mode);
      neg_a_r  <= neg_nxt;
      prd_a_r  <= prd_nxt;
    end
  end

  // stage B: sums and differences
  always_comb begin
    dot_nxt = vgu_pkg::DOT_W'(prd_a_r[0]) + vgu_pkg::DOT_W'(prd_a_r[1])
            + vgu_pkg::DOT_W'(prd_a_r[2]);
    for (int k = 0; k < 3; k++) begin
      crs_nxt[k] = vgu_pkg::CRS_W'(prd_a_r[2*k]) - vgu_pkg::CRS_W'(prd_a_r[2*k+1]);
    end
    s_nxt = vgu_pkg::SUM_W'(prd_a_r[0][vgu_pkg::SQ_W-1:0])
          + vgu_pkg::SUM_W'(prd_a_r[1][vgu_pkg::SQ_W-1:0])
          + vgu_pkg::SUM_W'(prd_a_r[2][vgu_pkg::SQ_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode_b_r <= mode_a_r;
      neg_b_r  <= neg_a_r;
      dot_b_r  <= dot_nxt;
      crs_b_r  <= crs_nxt;
      s_b_r    <= s_nxt;
      for (int k = 0; k < 3; k++) begin
        sq_b_r[k] <= prd_a_r[k][vgu_pkg::SQ_W-1:0];
      end
    end
  end

  // stage C: dot/cross rounding and saturation, perpendicular-test flag, tail seed
  always_comb begin
    vgu_pkg::sat_t st;
    st             = '0;
    dat_c_nxt      = '0;
    dat_c_nxt.mode = mode_b_r;
    dat_c_nxt.neg  = neg_b_r;
    dat_c_nxt.s    = s_b_r;
    for (int k = 0; k < 3; k++) begin
      dat_c_nxt.dv[k].rem = vgu_pkg::REM_W'(sq_b_r[k]);
    end
    dat_c_nxt.len.x = s_b_r;
    case (mode_b_r)
      vgu_pkg::MODE_DOT: begin
        st = vgu_pkg::sat_shift(dot_b_r);
        dat_c_nxt.sc = st.v;
        dat_c_nxt.ov = st.ov;
      end
      vgu_pkg::MODE_CROSS: begin
        for (int k = 0; k < 3; k++) begin
          st = vgu_pkg::sat_shift(vgu_pkg::DOT_W'(crs_b_r[k]));
          dat_c_nxt.r[k] = st.v;
          dat_c_nxt.ov   = dat_c_nxt.ov | st.ov;
        end
      end
      vgu_pkg::MODE_PTEST: begin
        dat_c_nxt.flag = (dot_b_r == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_c_r <= dat_c_nxt;
    end
  end

  assign out_vld = vld_c_r;
  assign out_dat = dat_c_r;

endmodule

@@ rtl/core/vgu_iter.sv @@
// Iterative tail: divide steps (with length root alongside), then component roots.
module vgu_iter (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  vgu_pkg::tail_t in_dat,
  output logic           out_vld,
  output vgu_pkg::tail_t out_dat
);

  vgu_pkg::tail_t st_r  [vgu_pkg::TAIL_STAGES];
  logic           vld_r [vgu_pkg::TAIL_STAGES];

  for (genvar j = 0; j < vgu_pkg::TAIL_STAGES; j++) begin : g_stg
    vgu_pkg::tail_t prv, nxt;
    logic           prv_v;

    if (j == 0) begin : g_first
      assign prv   = in_dat;
      assign prv_v = in_vld;
    end else begin : g_rest
      assign prv   = st_r[j-1];
      assign prv_v = vld_r[j-1];
    end

    if (j < vgu_pkg::DIV_STEPS) begin : g_div
      always_comb begin
        nxt = prv;
        for (int k = 0; k < 3; k++) begin
          nxt.dv[k] = vgu_pkg::div_step(prv.dv[k], prv.s, (j != 0));
        end
        if (j < vgu_pkg::LEN_STEPS) begin
          nxt.len = vgu_pkg::lsq_step(prv.len,
                      vgu_pkg::SUM_W'(1) << (vgu_pkg::SUM_W - 2 - 2*j));
        end
      end
    end else begin : g_nrm
      localparam int K = j - vgu_pkg::DIV_STEPS;
      always_comb begin
        vgu_pkg::nsq_t seed;
        nxt = prv;
        for (int k = 0; k < 3; k++) begin
          if (K == 0) begin
            seed.x   = vgu_pkg::NRM_XW'(prv.dv[k].q);
            seed.res = '0;
          end else begin
            seed = prv.nrm[k];
          end
          nxt.nrm[k] = vgu_pkg::nsq_step(seed,
                         vgu_pkg::NRM_XW'(1) << (vgu_pkg::NRM_XW - 2 - 2*K));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= prv_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= nxt;
      end
    end
  end

  assign out_vld = vld_r[vgu_pkg::TAIL_STAGES-1];
  assign out_dat = st_r[vgu_pkg::TAIL_STAGES-1];

endmodule

@@ rtl/core/vector3_geometry_unit_core.sv @@
// Channel   | Valid      | Stall      | Payload
// ----------+------------+------------+--------------------------------------------------
// input     | in_valid   | in_stall   | in_mode, in_a_x/y/z, in_b_x/y/z
// result    | out_valid  | out_stall  | out_r_x/y/z, out_scalar_out, out_flag, out_overflow
//
// One transaction per cycle sustained when the output is not stalled; every result passes through
// 3 multiply/sum stages, 33 divide stages, 17 root stages and 1 output register.
// The divide and root chains set the depth: one quotient or root bit per stage.
// rst_n is synchronous and clears only the valid bits; payload registers are left as is.
// A stalled result freezes the whole pipeline together, so in_stall follows
// out_valid & out_stall; no transaction is dropped or repeated.
`include "vector3_geometry_unit_core_assert.svh"

module vector3_geometry_unit_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_mode,
  input  logic signed [31:0]  in_a_x,
  input  logic signed [31:0]  in_a_y,
  input  logic signed [31:0]  in_a_z,
  input  logic signed [31:0]  in_b_x,
  input  logic signed [31:0]  in_b_y,
  input  logic signed [31:0]  in_b_z,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_r_x,
  output logic signed [31:0]  out_r_y,
  output logic signed [31:0]  out_r_z,
  output logic signed [31:0]  out_scalar_out,
  output logic                out_flag,
  output logic                out_overflow
);

  // pipeline advance: everything moves unless a finished result is held
  logic en;

  logic           fr_vld, tl_vld;
  vgu_pkg::tail_t fr_dat, tl_dat;

  vgu_pkg::comp_t [2:0] r_nxt;
  vgu_pkg::comp_t       sc_nxt;
  logic                 flag_nxt, ov_nxt;

  logic                 out_valid_r;
  vgu_pkg::comp_t [2:0] r_r;
  vgu_pkg::comp_t       sc_r;
  logic                 flag_r, ov_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  vgu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .mode    (in_mode),
    .a_x     (in_a_x),
    .a_y     (in_a_y),
    .a_z     (in_a_z),
    .b_x     (in_b_x),
    .b_y     (in_b_y),
    .b_z     (in_b_z),
    .out_vld (fr_vld),
    .out_dat (fr_dat)
  );

  vgu_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (fr_vld),
    .in_dat  (fr_dat),
    .out_vld (tl_vld),
    .out_dat (tl_dat)
  );

  // final assembly: length clamp, signed unit components, zero-vector case
  always_comb begin
    r_nxt    = tl_dat.r;
    sc_nxt   = tl_dat.sc;
    flag_nxt = tl_dat.flag;
    ov_nxt   = tl_dat.ov;
    case (tl_dat.mode)
      vgu_pkg::MODE_LEN: begin
        if (tl_dat.len.res[vgu_pkg::SUM_W-1:vgu_pkg::COMP_W-1] != '0) begin
          sc_nxt = vgu_pkg::COMP_MAX;
          ov_nxt = 1'b1;
        end else begin
          sc_nxt = tl_dat.len.res[vgu_pkg::COMP_W-1:0];
        end
      end
      vgu_pkg::MODE_NORM, vgu_pkg::MODE_PERP: begin
        if (tl_dat.s == '0) begin
          r_nxt    = '0;
          flag_nxt = 1'b0;
        end else begin
          for (int k = 0; k < 3; k++) begin
            r_nxt[k] = vgu_pkg::COMP_W'(tl_dat.nrm[k].res[vgu_pkg::NRM_W-1:0]);
            if (tl_dat.neg[k]) begin
              r_nxt[k] = -r_nxt[k];
            end
          end
          flag_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tl_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r    <= r_nxt;
      sc_r   <= sc_nxt;
      flag_r <= flag_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_r_x        = r_r[0];
  assign out_r_y        = r_r[1];
  assign out_r_z        = r_r[2];
  assign out_scalar_out = sc_r;
  assign out_flag       = flag_r;
  assign out_overflow   = ov_r;

  // a flagged result never carries a clamp, and scalar and vector never both clamp
  `VGU_ASSERT_IMPL(a_flag_no_ov, out_valid && out_flag, !out_overflow && out_scalar_out == '0)
  `VGU_ASSERT_IMPL(a_ov_one_side, out_valid && out_overflow,
                   out_scalar_out == '0 || (out_r_x == '0 && out_r_y == '0 && out_r_z == '0))
  // a transaction waiting at the tail is not lost while the output is held
  `VGU_ASSERT_NEXT(a_tail_hold, tl_vld && !en, tl_vld)

endmodule
